// ----- rtl/trial_division_prime_counter_assert.svh -----
// Assertion macros for the trial division prime counter.
// Each macro expands to a concurrent assertion clocked by clk and held off
// during reset; with SYNTH defined they expand to nothing.
`ifndef TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_ASSERT_SVH

`ifndef SYNTH

// Condition that holds at every clock edge.
`define TDPC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TDPC_ASSERT(lbl, cond, msg)
`define TDPC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/tdpc_pkg.sv -----
`default_nettype none
package tdpc_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int TALLY_W = 32;
	localparam int FIRST_DIVISOR = 2;
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	// remainder unit status, seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
		logic rem_zero;
	} rem_stat_t;

	// sequencer status, seen by the top level
	typedef struct packed {
		logic idle;
		logic done;
		logic prime;
	} seq_stat_t;

endpackage
`default_nettype wire

// ----- rtl/tdpc_in_if.sv -----
`default_nettype none
interface tdpc_in_if #(
	parameter int W = tdpc_pkg::VALUE_WIDTH_DEF
);
	logic         valid;
	logic         ready;
	logic [W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// ----- rtl/tdpc_out_if.sv -----
`default_nettype none
interface tdpc_out_if;
	logic                         valid;
	logic                         ready;
	logic                         is_prime;
	logic [tdpc_pkg::TALLY_W-1:0] prime_total;

	modport source (output valid, output is_prime, output prime_total, input ready);
	modport sink (input valid, input is_prime, input prime_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/trial_division_prime_counter.sv -----
// Channel   Role    Payload                     Transaction
// request   sink    value[VALUE_WIDTH-1:0]      valid && ready
// result    source  is_prime, prime_total[31:0] valid && ready
//
// One value at a time. Values 0 and 1 go straight to finish. Each trial divisor
// takes a bound check, VALUE_WIDTH restoring remainder steps and a decision.
// A prime finishes once d*d exceeds the value; a composite finishes on the zero
// remainder of its smallest factor p.
// Reset clears the sequencer, the output valid and the prime tally. A stalled
// result holds in the output register; the next value is taken and waits in finish.
`default_nettype none
module trial_division_prime_counter #(
	parameter int VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	tdpc_in_if.sink    request,
	tdpc_out_if.source result
);
	// divisor reaches at most 2^ceil(VALUE_WIDTH/2), so one extra bit holds it
	localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 1;

	tdpc_pkg::rem_stat_t          rem_stat;
	tdpc_pkg::seq_stat_t          seq_stat;
	logic                         rem_start;
	logic [VALUE_WIDTH-1:0]       dividend;
	logic [DIV_W-1:0]             divisor;
	logic                         slot_free;
	logic                         accept;

	logic                         out_valid_q;
	logic                         is_prime_q;
	logic [tdpc_pkg::TALLY_W-1:0] total_q;
	logic [tdpc_pkg::TALLY_W-1:0] tally_q;
	logic [tdpc_pkg::TALLY_W-1:0] tally_next;

	// take a new value only while the sequencer is idle
	assign request.ready = seq_stat.idle;
	assign accept        = request.valid && request.ready;

	// the output register can take a result when empty or draining this cycle
	assign slot_free = !out_valid_q || result.ready;

	tdpc_sequencer #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIV_W       (DIV_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.value     (request.value),
		.slot_free (slot_free),
		.rem_stat  (rem_stat),
		.rem_start (rem_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.stat      (seq_stat)
	);

	tdpc_rem_unit #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.DIV_W       (DIV_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (rem_stat)
	);

	// advance the tally on a prime, hold it at its maximum
	always_comb begin
		tally_next = tally_q;
		if (seq_stat.prime && tally_q != tdpc_pkg::TALLY_MAX) begin
			tally_next = tally_q + tdpc_pkg::TALLY_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tally_q     <= '0;
		end else begin
			if (seq_stat.done) begin
				out_valid_q <= 1'b1;
				tally_q     <= tally_next;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload: loaded with the flag and the updated tally
	always_ff @(posedge clk) begin
		if (seq_stat.done) begin
			is_prime_q <= seq_stat.prime;
			total_q    <= tally_next;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.is_prime    = is_prime_q;
	assign result.prime_total = total_q;

`include "trial_division_prime_counter_assert.svh"

	`TDPC_ASSERT(a_finish_into_free_slot, !seq_stat.done || slot_free, "result lost")
	`TDPC_ASSERT(a_idle_no_divide, !seq_stat.idle || !rem_stat.busy, "idle while dividing")
	`TDPC_ASSERT_NEXT(a_tally_monotonic, 1'b1, tally_q >= $past(tally_q), "tally decreased")
	`TDPC_ASSERT_NEXT(a_prime_counts, seq_stat.done && seq_stat.prime && tally_q != tdpc_pkg::TALLY_MAX, result.prime_total == $past(tally_q) + tdpc_pkg::TALLY_W'(1), "prime not counted")
	`TDPC_ASSERT_NEXT(a_composite_holds, seq_stat.done && !seq_stat.prime, result.prime_total == $past(tally_q), "tally moved on composite")
endmodule
`default_nettype wire

// ----- rtl/tdpc_rem_unit.sv -----
`default_nettype none
// Restoring remainder unit: one dividend bit per cycle, VALUE_WIDTH bits per start.
module tdpc_rem_unit #(
	parameter int VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH_DEF,
	parameter int DIV_W = (VALUE_WIDTH + 1) / 2 + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dividend,
	input  wire logic [DIV_W-1:0]       divisor,
	output tdpc_pkg::rem_stat_t         stat
);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] sh_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W:0]         trial;
	logic [DIV_W-1:0]       rem_next;

	// shift the next dividend bit in, subtract the divisor when it fits
	always_comb begin
		trial = {rem_q, sh_q[VALUE_WIDTH-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = DIV_W'(trial - {1'b0, divisor});
		end else begin
			rem_next = trial[DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << 1;
			rem_q <= rem_next;
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);
endmodule
`default_nettype wire

// ----- rtl/tdpc_sequencer.sv -----
`default_nettype none
// Divisor sequencer: steps d and d*d, launches one remainder per divisor.
module tdpc_sequencer #(
	parameter int VALUE_WIDTH = tdpc_pkg::VALUE_WIDTH_DEF,
	parameter int DIV_W = (VALUE_WIDTH + 1) / 2 + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] value,
	input  wire logic                   slot_free,
	input  wire tdpc_pkg::rem_stat_t    rem_stat,
	output logic                        rem_start,
	output logic [VALUE_WIDTH-1:0]      dividend,
	output logic [DIV_W-1:0]            divisor,
	output tdpc_pkg::seq_stat_t         stat
);
	localparam int SQ_W = VALUE_WIDTH + 2;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_BOUND  = 2'd1;
	localparam logic [1:0] ST_DIVIDE = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] v_q;
	logic [DIV_W-1:0]       d_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   prime_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prime_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (value < VALUE_WIDTH'(tdpc_pkg::FIRST_DIVISOR)) begin
							prime_q <= 1'b0;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_BOUND;
						end
					end
				end
				ST_BOUND: begin
					if (sq_q > {2'b00, v_q}) begin
						prime_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (rem_stat.done) begin
						if (rem_stat.rem_zero) begin
							prime_q <= 1'b0;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_BOUND;
						end
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operands: load on start, advance d and d*d after a nonzero remainder
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			v_q  <= value;
			d_q  <= DIV_W'(tdpc_pkg::FIRST_DIVISOR);
			sq_q <= SQ_W'(tdpc_pkg::FIRST_DIVISOR * tdpc_pkg::FIRST_DIVISOR);
		end else if (state_q == ST_DIVIDE && rem_stat.done && !rem_stat.rem_zero) begin
			d_q  <= d_q + DIV_W'(1);
			sq_q <= sq_q + SQ_W'({d_q, 1'b1});
		end
	end

	assign rem_start  = (state_q == ST_BOUND) && !(sq_q > {2'b00, v_q});
	assign dividend   = v_q;
	assign divisor    = d_q;
	assign stat.idle  = (state_q == ST_IDLE);
	assign stat.done  = (state_q == ST_FINISH) && slot_free;
	assign stat.prime = prime_q;
endmodule
`default_nettype wire
